FILE: hw/rtl/rational_arithmetic_unit_top_assert.svh
// Assertion macros for the checker module of the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RAU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rational unit check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RAU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rational unit check failed");

`endif

FILE: hw/rtl/rau_pkg.sv
`default_nettype none
package rau_pkg;

    // Operand width; each operand port carries this many live bits.
    localparam int OPERAND_WIDTH = 32;
    // Width of products, sums and reduced magnitudes.
    localparam int PW = 2 * OPERAND_WIDTH;
    // Bit counter width for the serial divider.
    localparam int CNT_W = $clog2(PW);

    // Operand slots inside a queue entry.
    localparam int IDX_AN = 0;
    localparam int IDX_AD = 1;
    localparam int IDX_BN = 2;
    localparam int IDX_BD = 3;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_DIV_ZERO = 2'd2,
        ST_RSVD     = 2'd3
    } status_t;

    // One classified item in sign and magnitude form.
    typedef struct packed {
        cmd_t                            cmd;
        status_t                         status;
        logic [3:0]                      neg;
        logic [3:0][OPERAND_WIDTH-1:0]   mag;
    } entry_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rational_arithmetic_unit_top.sv
// Rational arithmetic unit.
// Input channel (s_): one beat carries an operation code (add, subtract,
// multiply, divide) and two signed fractions a_num/a_den and b_num/b_den.
// Output channel (m_): one beat per input beat, in order, carrying the
// result reduced to lowest terms with a positive denominator and a status.
// A zero operand denominator or a division by zero gives an error status
// with zero numerator and denominator; a zero result is 0/1.
// An error beat goes from the queue straight to the output register, and a
// zero result skips the gcd loop and the divisions. Any other beat passes the
// queue, multiplication in S_MUL0, S_MUL1 and S_MUL2 on the shared 32x32
// multiplier, the combine state S_ADD, the binary gcd loop (data-dependent
// subtract or shift steps), two bit-serial divisions and the output register.
// The back end takes a new beat only once the last one has gone to the output
// register; a two-beat queue decouples the input side, so beats are taken
// while a result waits on a stalled receiver. A stalled receiver holds the
// output register, and the back end waits.
// Reset (aresetn, synchronous, active low) empties the queue and drops
// m_valid; no clearing pass is needed.
`default_nettype none
module rational_arithmetic_unit_top import rau_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic        [1:0]  s_cmd,
    input  wire logic signed [31:0] s_a_num,
    input  wire logic signed [31:0] s_a_den,
    input  wire logic signed [31:0] s_b_num,
    input  wire logic signed [31:0] s_b_den,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [63:0]      m_res_num,
    output logic        [62:0]      m_res_den,
    output logic        [1:0]       m_status
);

    logic   q_valid;
    logic   q_ready;
    entry_t q_entry;

    // Front end: classification and queue.
    rau_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .s_a_num (s_a_num),
        .s_a_den (s_a_den),
        .s_b_num (s_b_num),
        .s_b_den (s_b_den),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_entry (q_entry)
    );

    // Back end: arithmetic, reduction and output register.
    rau_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_entry   (q_entry),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res_num (m_res_num),
        .m_res_den (m_res_den),
        .m_status  (m_status)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/rau_front.sv
`default_nettype none
module rau_front import rau_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [31:0] s_a_num,
    input  wire logic [31:0] s_a_den,
    input  wire logic [31:0] s_b_num,
    input  wire logic [31:0] s_b_den,
    output logic             q_valid,
    input  wire logic        q_ready,
    output entry_t           q_entry
);

    logic [3:0][OPERAND_WIDTH-1:0] raw;
    entry_t                        ent;
    entry_t                        mem_reg [2];
    logic                          wr_ptr_reg, wr_ptr_next;
    logic                          rd_ptr_reg, rd_ptr_next;
    logic [1:0]                    cnt_reg, cnt_next;
    logic                          push, pop;

    // Classify the beat: sign and magnitude of each operand, and its status.
    always_comb begin
        raw[IDX_AN] = s_a_num[OPERAND_WIDTH-1:0];
        raw[IDX_AD] = s_a_den[OPERAND_WIDTH-1:0];
        raw[IDX_BN] = s_b_num[OPERAND_WIDTH-1:0];
        raw[IDX_BD] = s_b_den[OPERAND_WIDTH-1:0];
        ent.cmd = cmd_t'(s_cmd);
        for (int i = 0; i < 4; i++) begin
            ent.neg[i] = raw[i][OPERAND_WIDTH-1];
            ent.mag[i] = raw[i][OPERAND_WIDTH-1] ? (~raw[i] + 1'b1) : raw[i];
        end
        if (raw[IDX_AD] == '0 || raw[IDX_BD] == '0) begin
            ent.status = ST_ZERO_DEN;
        end else if (ent.cmd == CMD_DIV && raw[IDX_BN] == '0) begin
            ent.status = ST_DIV_ZERO;
        end else begin
            ent.status = ST_OK;
        end
    end

    // Two-entry queue towards the back end.
    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_entry = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= ent;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/rau_back.sv
`default_nettype none
module rau_back import rau_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    output logic                    q_ready,
    input  wire entry_t             q_entry,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [63:0]      m_res_num,
    output logic        [62:0]      m_res_den,
    output logic        [1:0]       m_status
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_ADD, S_GCD, S_DIVN, S_DIVD, S_DONE
    } state_t;

    state_t             state_reg;
    entry_t             ent_reg;
    logic               t1_neg_reg, t2_neg_reg, d_neg_reg, n_neg_reg;
    logic [PW-1:0]      t1_reg, t2_reg, d_reg, n_reg;
    logic [PW-1:0]      u_reg, v_reg;
    logic [PW-1:0]      q_reg, rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    status_t            st_reg;
    logic               m_valid_reg;
    logic signed [63:0] m_num_reg;
    logic        [62:0] m_den_reg;
    logic        [1:0]  m_status_reg;

    logic [OPERAND_WIDTH-1:0] mul_x, mul_y;
    logic                     mul_neg;
    logic [PW-1:0]            prod;
    logic [PW-1:0]            sum_mag;
    logic                     sum_neg;
    logic [PW:0]              div_tmp;
    logic                     div_bit;
    logic [PW-1:0]            nm_sat;

    assign q_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_res_num = m_num_reg;
    assign m_res_den = m_den_reg;
    assign m_status  = m_status_reg;

    // Operand selection for the shared magnitude multiplier.
    always_comb begin
        mul_x   = ent_reg.mag[IDX_AD];
        mul_y   = ent_reg.mag[IDX_BD];
        mul_neg = ent_reg.neg[IDX_AD] ^ ent_reg.neg[IDX_BD];
        case (state_reg)
            S_MUL0: begin
                mul_x = ent_reg.mag[IDX_AN];
                if (ent_reg.cmd == CMD_MUL) begin
                    mul_y   = ent_reg.mag[IDX_BN];
                    mul_neg = ent_reg.neg[IDX_AN] ^ ent_reg.neg[IDX_BN];
                end else begin
                    mul_neg = ent_reg.neg[IDX_AN] ^ ent_reg.neg[IDX_BD];
                end
            end
            S_MUL1: begin
                mul_y   = (ent_reg.cmd == CMD_ADD || ent_reg.cmd == CMD_SUB)
                          ? ent_reg.mag[IDX_BN] : '0;
                mul_neg = ent_reg.neg[IDX_AD] ^ ent_reg.neg[IDX_BN]
                          ^ (ent_reg.cmd == CMD_SUB);
            end
            S_MUL2: begin
                if (ent_reg.cmd == CMD_DIV) begin
                    mul_y   = ent_reg.mag[IDX_BN];
                    mul_neg = ent_reg.neg[IDX_AD] ^ ent_reg.neg[IDX_BN];
                end
            end
            default: begin
                mul_x = ent_reg.mag[IDX_AD];
            end
        endcase
        prod = PW'(mul_x) * PW'(mul_y);
    end

    // Signed-magnitude sum of the two numerator terms.
    always_comb begin
        if (t1_neg_reg == t2_neg_reg) begin
            sum_mag = t1_reg + t2_reg;
            sum_neg = t1_neg_reg;
        end else if (t1_reg >= t2_reg) begin
            sum_mag = t1_reg - t2_reg;
            sum_neg = t1_neg_reg;
        end else begin
            sum_mag = t2_reg - t1_reg;
            sum_neg = t2_neg_reg;
        end
    end

    // One restoring division step by the gcd.
    always_comb begin
        div_tmp = {rem_reg, q_reg[PW-1]};
        div_bit = (div_tmp >= {1'b0, u_reg});
    end

    assign nm_sat = n_reg[PW-1] ? {1'b0, {(PW-1){1'b1}}} : n_reg;

    // Sequencer: multiply, combine, binary gcd, two serial divisions, output.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        ent_reg <= q_entry;
                        st_reg  <= q_entry.status;
                        n_reg   <= '0;
                        d_reg   <= '0;
                        n_neg_reg <= 1'b0;
                        state_reg <= (q_entry.status == ST_OK) ? S_MUL0 : S_DONE;
                    end
                end
                S_MUL0: begin
                    t1_reg     <= prod;
                    t1_neg_reg <= mul_neg;
                    state_reg  <= S_MUL1;
                end
                S_MUL1: begin
                    t2_reg     <= prod;
                    t2_neg_reg <= mul_neg;
                    state_reg  <= S_MUL2;
                end
                S_MUL2: begin
                    d_reg     <= prod;
                    d_neg_reg <= mul_neg;
                    state_reg <= S_ADD;
                end
                S_ADD: begin
                    n_reg     <= sum_mag;
                    n_neg_reg <= (sum_neg ^ d_neg_reg) && (sum_mag != '0);
                    u_reg     <= sum_mag;
                    v_reg     <= d_reg;
                    if (sum_mag == '0) begin
                        d_reg     <= PW'(1);
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (!u_reg[0] && !v_reg[0]) begin
                        // Common factor of two: strip it from the fraction too.
                        u_reg <= u_reg >> 1;
                        v_reg <= v_reg >> 1;
                        n_reg <= n_reg >> 1;
                        d_reg <= d_reg >> 1;
                    end else if (!u_reg[0]) begin
                        u_reg <= u_reg >> 1;
                    end else if (!v_reg[0]) begin
                        v_reg <= v_reg >> 1;
                    end else if (u_reg == v_reg) begin
                        q_reg     <= n_reg;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIVN;
                    end else if (u_reg > v_reg) begin
                        u_reg <= u_reg - v_reg;
                    end else begin
                        v_reg <= v_reg - u_reg;
                    end
                end
                S_DIVN: begin
                    if (cnt_reg == CNT_W'(PW - 1)) begin
                        n_reg     <= {q_reg[PW-2:0], div_bit};
                        q_reg     <= d_reg;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIVD;
                    end else begin
                        rem_reg <= div_bit ? PW'(div_tmp - {1'b0, u_reg}) : div_tmp[PW-1:0];
                        q_reg   <= {q_reg[PW-2:0], div_bit};
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DIVD: begin
                    if (cnt_reg == CNT_W'(PW - 1)) begin
                        d_reg     <= {q_reg[PW-2:0], div_bit};
                        state_reg <= S_DONE;
                    end else begin
                        rem_reg <= div_bit ? PW'(div_tmp - {1'b0, u_reg}) : div_tmp[PW-1:0];
                        q_reg   <= {q_reg[PW-2:0], div_bit};
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_num_reg    <= n_neg_reg ? -$signed(64'(nm_sat)) : $signed(64'(nm_sat));
                        m_den_reg    <= 63'(d_reg);
                        m_status_reg <= st_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/rau_checker.sv
`default_nettype none
`include "rational_arithmetic_unit_top_assert.svh"
module rau_checker import rau_pkg::*; (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [63:0] m_res_num,
    input wire logic        [62:0] m_res_den,
    input wire logic        [1:0]  m_status
);

    // An error beat carries a zero fraction.
    `RAU_ASSERT_IMP(err_zero_frac, aclk, aresetn, m_valid && m_status != ST_OK, m_res_num == '0 && m_res_den == '0)
    // A good beat always has a nonzero denominator.
    `RAU_ASSERT_IMP(ok_den_nonzero, aclk, aresetn, m_valid && m_status == ST_OK, m_res_den != '0)
    // The reserved status code is never produced.
    `RAU_ASSERT_IMP(no_rsvd_status, aclk, aresetn, m_valid, m_status != ST_RSVD)
    // A stalled result beat stays offered.
    `RAU_ASSERT_NXT(out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_res_num))

endmodule

bind rational_arithmetic_unit_top rau_checker u_rau_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_res_num (m_res_num),
    .m_res_den (m_res_den),
    .m_status  (m_status)
);
`default_nettype wire

FILE: bench/testbench.sv
`default_nettype none
module testbench;
    import rau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic        [1:0]  s_cmd;
    logic signed [31:0] s_a_num;
    logic signed [31:0] s_a_den;
    logic signed [31:0] s_b_num;
    logic signed [31:0] s_b_den;
    logic               m_valid;
    logic               m_ready;
    logic signed [63:0] m_res_num;
    logic        [62:0] m_res_den;
    logic        [1:0]  m_status;

    typedef struct {
        logic signed [63:0] num;
        logic        [62:0] den;
        status_t            status;
    } fraction_t;

    fraction_t   pending_fractions[$];
    int unsigned mismatch_count;
    bit          recv_pause_long;
    int unsigned recv_stall_left;

    rational_arithmetic_unit_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .s_a_num   (s_a_num),
        .s_a_den   (s_a_den),
        .s_b_num   (s_b_num),
        .s_b_den   (s_b_den),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res_num (m_res_num),
        .m_res_den (m_res_den),
        .m_status  (m_status)
    );

    // Clock generation.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic logic [63:0] euclid_gcd(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Expected reduced fraction for one operation; products of 32-bit operands
    // fit in 64 bits, and each sum is done in 66-bit signed arithmetic.
    function automatic fraction_t reduce_fraction(input cmd_t op, input logic signed [31:0] an,
                                                  input logic signed [31:0] ad,
                                                  input logic signed [31:0] bn,
                                                  input logic signed [31:0] bd);
        fraction_t          r;
        logic signed [65:0] num;
        logic signed [65:0] den;
        logic        [65:0] nm;
        logic        [65:0] dm;
        logic        [63:0] g;
        r.num = '0;
        r.den = '0;
        r.status = ST_OK;
        if (ad == 0 || bd == 0) begin
            r.status = ST_ZERO_DEN;
            return r;
        end
        if (op == CMD_DIV && bn == 0) begin
            r.status = ST_DIV_ZERO;
            return r;
        end
        case (op)
            CMD_ADD: begin
                num = 66'(an) * 66'(bd) + 66'(ad) * 66'(bn);
                den = 66'(ad) * 66'(bd);
            end
            CMD_SUB: begin
                num = 66'(an) * 66'(bd) - 66'(ad) * 66'(bn);
                den = 66'(ad) * 66'(bd);
            end
            CMD_MUL: begin
                num = 66'(an) * 66'(bn);
                den = 66'(ad) * 66'(bd);
            end
            default: begin
                num = 66'(an) * 66'(bd);
                den = 66'(ad) * 66'(bn);
            end
        endcase
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        nm = (num < 0) ? -num : num;
        dm = den;
        g  = euclid_gcd(nm[63:0], dm[63:0]);
        nm = nm / g;
        dm = dm / g;
        if (nm > 66'h7FFF_FFFF_FFFF_FFFF)
            nm = 66'h7FFF_FFFF_FFFF_FFFF;
        r.num = (num < 0) ? -nm[63:0] : nm[63:0];
        r.den = dm[62:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic int unsigned gap_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 300);
        return $urandom_range(0, 3);
    endfunction

    // Sends one beat and records its expected result.
    task automatic send_fraction_pair(input cmd_t op, input logic [31:0] an, input logic [31:0] ad,
                                      input logic [31:0] bn, input logic [31:0] bd,
                                      input int gaps);
        int unsigned n;
        n = (gaps != 0) ? gap_length() : 0;
        repeat (n) @(negedge aclk);
        s_valid = 1'b1;
        s_cmd   = op;
        s_a_num = an;
        s_a_den = ad;
        s_b_num = bn;
        s_b_den = bd;
        pending_fractions.push_back(reduce_fraction(op, an, ad, bn, bd));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Result checker.
    always @(posedge aclk) begin
        fraction_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_fractions.size() == 0) begin
                report_mismatch("unexpected beat", m_res_num, '0);
            end else begin
                want = pending_fractions.pop_front();
                if (m_status !== want.status)
                    report_mismatch("status", 64'(m_status), 64'(want.status));
                if (m_res_num !== want.num)
                    report_mismatch("res_num", m_res_num, want.num);
                if (m_res_den !== want.den)
                    report_mismatch("res_den", 64'(m_res_den), 64'(want.den));
            end
        end
    end

    // Receiver back-pressure: mostly short stalls, now and then a long one,
    // and stretches of no stalling.
    always @(negedge aclk) begin
        if (!aresetn || recv_pause_long) begin
            m_ready <= 1'b1;
            recv_stall_left = 0;
        end else if (recv_stall_left != 0) begin
            m_ready <= 1'b0;
            recv_stall_left--;
        end else if ($urandom_range(0, 49) == 0) begin
            m_ready <= 1'b0;
            recv_stall_left = $urandom_range(20, 200);
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 15) - 8;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0001;
            default: return $urandom();
        endcase
    endfunction

    task automatic wait_for_results();
        while (pending_fractions.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic test_directed_cases();
        send_fraction_pair(CMD_ADD, 1, 2, 1, 3, 0);
        send_fraction_pair(CMD_SUB, 1, 2, 1, 2, 0);
        send_fraction_pair(CMD_MUL, -3, 4, 4, -3, 0);
        send_fraction_pair(CMD_DIV, 6, -4, -3, 8, 0);
        send_fraction_pair(CMD_ADD, 0, -5, 0, 7, 0);
        send_fraction_pair(CMD_ADD, 1, 0, 1, 1, 0);
        send_fraction_pair(CMD_DIV, 1, 1, 1, 0, 0);
        send_fraction_pair(CMD_DIV, 5, 3, 0, 9, 0);
        send_fraction_pair(CMD_MUL, 0, 0, 0, 0, 0);
        send_fraction_pair(CMD_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_fraction_pair(CMD_SUB, 32'h8000_0000, 1, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_fraction_pair(CMD_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1, 0);
        send_fraction_pair(CMD_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_fraction_pair(CMD_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFD, 32'h7FFF_FFFF, 0);
        send_fraction_pair(CMD_SUB, -1, -1, -1, -1, 0);
        send_fraction_pair(CMD_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0001, 32'h8000_0001, 0);
        wait_for_results();
    endtask

    task automatic test_random_operations();
        cmd_t op;
        for (int i = 0; i < 900; i++) begin
            op = cmd_t'($urandom_range(0, 3));
            send_fraction_pair(op, random_operand(), random_operand(),
                               random_operand(), random_operand(), 1);
            // Hold off now and then until the block has drained.
            if (i % 300 == 150)
                wait_for_results();
        end
    endtask

    task automatic test_no_stall_burst();
        recv_pause_long = 1'b1;
        for (int i = 0; i < 30; i++)
            send_fraction_pair(cmd_t'(i % 4), $urandom(), $urandom(), $urandom(),
                               $urandom(), 0);
        wait_for_results();
        recv_pause_long = 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cmd   = '0;
        s_a_num = '0;
        s_a_den = '0;
        s_b_num = '0;
        s_b_den = '0;
        recv_pause_long = 1'b0;
        mismatch_count = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_cases();
        test_no_stall_burst();
        test_random_operations();

        wait_for_results();
        repeat (300) @(posedge aclk);
        if (mismatch_count == 0 && pending_fractions.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog.
    initial begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
